@@ hdl/gsfp_pkg.sv @@
package gsfp_pkg;

    // Serial byte as received from the sensor.
    typedef logic [7:0] byte_t;

    // Frame position: 0..9 count received frame bytes, IDLE_POS means not in a frame.
    typedef logic [3:0] pos_t;

    localparam byte_t START_FIRST  = 8'h3C;
    localparam byte_t START_SECOND = 8'h04;

    localparam int    FRAME_LEN     = 10;
    localparam int    READING_BYTES = 8;
    localparam pos_t  IDLE_POS      = 4'd15;
    localparam pos_t  LAST_POS      = 4'(FRAME_LEN - 1);
    localparam pos_t  READING_END   = 4'(READING_BYTES);

    // Running check sum starts with both start bytes already added.
    localparam byte_t SUM_SEED = 8'(START_FIRST + START_SECOND);

endpackage

@@ hdl/gas_sensor_frame_parser.sv @@
// Gas sensor frame parser.
// The rx channel (rx_valid, rx_ready, rx_byte) takes one received serial byte
// per request. While idle the parser looks for the start pair 0x3C 0x04; the
// ten bytes that follow form a frame, the last of which is the check byte.
// The res channel (res_valid, res_ready and the result fields) gives one
// request per completed frame: frame_ok and the four latched readings, which
// are updated only when the check byte matches.
// Timing: a byte is registered on acceptance and processed straight from the
// input register; res_valid is registered when the last byte of a frame
// leaves the input register.
// Throughput: one byte per cycle unless a frame-ending byte waits, set by the
// single input register stage and the one-byte-a-cycle running check sum.
// When the receiver stalls, a pending result holds; bytes that do not finish
// a frame keep flowing, and only a frame-ending byte waits in the input
// register, which lowers rx_ready until the result is taken.
// Reset (rst_n low, asynchronous) clears the previous byte and the readings
// to zero, sets the frame position to idle and empties both registers.
module gas_sensor_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        frame_ok,
    output logic [15:0] oxygen_raw,
    output logic [15:0] carbon_monoxide_raw,
    output logic [15:0] hydrogen_sulfide_raw,
    output logic [15:0] methane_raw
);

    // Input register.
    logic                in_valid_reg;
    gsfp_pkg::byte_t     in_byte_reg;

    // Parser state.
    gsfp_pkg::byte_t     prev_reg,  prev_next;
    gsfp_pkg::pos_t      pos_reg,   pos_next;
    gsfp_pkg::byte_t     sum_reg,   sum_next;
    gsfp_pkg::byte_t     store_reg [gsfp_pkg::READING_BYTES];

    // Result register; the readings themselves are the latched outputs.
    logic                res_valid_reg, res_valid_next;
    logic                ok_reg,        ok_next;
    logic [15:0]         o2_reg, co_reg, h2s_reg, ch4_reg;

    logic                ends_frame;
    logic                fire;
    logic                load_res;
    logic                sum_match;

    // A frame-ending byte needs a free result slot; other bytes go at once.
    assign ends_frame = (pos_reg == gsfp_pkg::LAST_POS);
    assign fire       = in_valid_reg && (!ends_frame || !res_valid_reg || res_ready);
    assign load_res   = fire && ends_frame;
    assign rx_ready   = !in_valid_reg || fire;
    assign sum_match  = (~sum_reg == in_byte_reg);

    // Input register load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Next-state logic for start detection, position, running sum and result flags.
    always_comb
    begin
        prev_next      = prev_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        ok_next        = ok_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (fire)
        begin
            prev_next = in_byte_reg;
            if (pos_reg < 4'(gsfp_pkg::FRAME_LEN))
            begin
                sum_next = sum_reg + in_byte_reg;
                if (ends_frame)
                begin
                    pos_next       = gsfp_pkg::IDLE_POS;
                    ok_next        = sum_match;
                    res_valid_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            else
            begin
                sum_next = gsfp_pkg::SUM_SEED;
                if (prev_reg == gsfp_pkg::START_FIRST && in_byte_reg == gsfp_pkg::START_SECOND)
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = gsfp_pkg::IDLE_POS;
                end
            end
        end
    end

    // Control and reading registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            pos_reg       <= gsfp_pkg::IDLE_POS;
            sum_reg       <= gsfp_pkg::SUM_SEED;
            res_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            o2_reg        <= '0;
            co_reg        <= '0;
            h2s_reg       <= '0;
            ch4_reg       <= '0;
        end
        else
        begin
            prev_reg      <= prev_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
            ok_reg        <= ok_next;
            if (load_res && sum_match)
            begin
                o2_reg  <= {store_reg[0], store_reg[1]};
                co_reg  <= {store_reg[2], store_reg[3]};
                h2s_reg <= {store_reg[4], store_reg[5]};
                ch4_reg <= {store_reg[6], store_reg[7]};
            end
        end
    end

    // Reading bytes of the frame are kept; bytes 8 and 9 only enter the sum.
    always_ff @(posedge clk)
    begin
        if (fire && pos_reg < gsfp_pkg::READING_END)
        begin
            store_reg[pos_reg[2:0]] <= in_byte_reg;
        end
    end

    assign res_valid            = res_valid_reg;
    assign frame_ok             = ok_reg;
    assign oxygen_raw           = o2_reg;
    assign carbon_monoxide_raw  = co_reg;
    assign hydrogen_sulfide_raw = h2s_reg;
    assign methane_raw          = ch4_reg;

    // The frame position is either inside a frame or idle.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= gsfp_pkg::LAST_POS) || (pos_reg == gsfp_pkg::IDLE_POS))
        else $error("frame position out of range");

    // A failed frame leaves the latched readings untouched.
    a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (load_res && !sum_match) |=> ($stable(oxygen_raw) && $stable(methane_raw)
            && $stable(carbon_monoxide_raw) && $stable(hydrogen_sulfide_raw)))
        else $error("readings changed on a failed frame");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |-> (!res_valid_reg || res_ready))
        else $error("pending result overwritten");

    // After a frame ends the parser is idle again.
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> (pos_reg == gsfp_pkg::IDLE_POS && res_valid_reg))
        else $error("parser not idle after frame");

endmodule
